/* rtl/mrps_pkg.sv */
// ----------------------------------------------------------------------------
// Metaball ribbon shader package
// Shared constants and types for the ball cells and the top level.
// ----------------------------------------------------------------------------
package mrps_pkg;

   localparam int NUM_BALLS = 10;
   localparam int IDX_W     = 6;
   localparam int CNT_W     = $clog2(NUM_BALLS + 1);
   localparam int DIV_STEPS = 24;
   localparam int DCNT_W    = 5;
   localparam int ACC_W     = 38;
   localparam logic [23:0] F_MAX = 24'hFFFFFF;

   localparam logic [1:0] REG_MIN_LEVEL = 2'd0;
   localparam logic [1:0] REG_MAX_LEVEL = 2'd1;
   localparam logic [1:0] REG_X_SCALE   = 2'd2;
   localparam logic [1:0] REG_Y_SCALE   = 2'd3;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   typedef struct packed {
      logic load_en;
      logic dist_en;
      logic div_start;
      logic div_step;
      logic mul_en;
      logic shift_en;
   } ctrl_type;

   typedef struct packed {
      logic [23:0] f;
      logic [31:0] r;
      logic [31:0] g;
      logic [31:0] b;
   } link_type;

endpackage

/* rtl/mrps_cell.sv */
// ----------------------------------------------------------------------------
// Metaball ribbon shader ball cell
// Holds one ball, computes its field at the current pixel with a serial
// divider and passes its weighted terms down the chain.
// ----------------------------------------------------------------------------
module mrps_cell
   import mrps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ctrl_type           ctrl,
   input  logic [IDX_W-1:0]   cell_index,
   input  logic [IDX_W-1:0]   load_index,
   input  logic signed [15:0] load_x,
   input  logic signed [15:0] load_y,
   input  logic [15:0]        load_radius,
   input  logic [23:0]        load_color,
   input  logic signed [15:0] cx,
   input  logic signed [15:0] cy,
   input  link_type           link_prev,
   output link_type           link_out
);

   logic signed [15:0] bx_ff, by_ff;
   logic [15:0]        rad_ff;
   logic [23:0]        col_ff;
   logic [32:0]        d2_ff;
   logic [31:0]        r2_ff;
   logic [43:0]        rem_ff, rem_in;
   logic [55:0]        den_ff;
   logic [23:0]        q_ff, q_in;
   logic               sat_ff;
   link_type           link_ff;

   logic signed [16:0] dx, dy;
   logic [15:0]        ax, ay;
   logic [23:0]        f_val;

   always_comb begin
      dx = 17'(cx) - 17'(bx_ff);
      dy = 17'(cy) - 17'(by_ff);
      ax = dx[16] ? 16'(-dx) : dx[15:0];
      ay = dy[16] ? 16'(-dy) : dy[15:0];
      // An inactive ball adds no field, even at its center where the divider
      // sees zero over zero.
      f_val = sat_ff ? F_MAX : ((r2_ff == '0) ? 24'd0 : q_ff);
      // One restoring step: unless saturated, the remainder stays below twice the shifted divisor.
      if ({12'b0, rem_ff} >= den_ff) begin
         rem_in = rem_ff - den_ff[43:0];
         q_in   = {q_ff[22:0], 1'b1};
      end else begin
         rem_in = rem_ff;
         q_in   = {q_ff[22:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bx_ff  <= '0;
         by_ff  <= '0;
         rad_ff <= '0;
         col_ff <= '0;
      end else if (ctrl.load_en && load_index == cell_index) begin
         bx_ff  <= load_x;
         by_ff  <= load_y;
         rad_ff <= load_radius;
         col_ff <= load_color;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.dist_en) begin
         d2_ff <= {1'b0, 32'(ax * ax)} + {1'b0, 32'(ay * ay)};
         r2_ff <= 32'(rad_ff * rad_ff);
      end
      if (ctrl.div_start) begin
         rem_ff <= {r2_ff, 12'b0};
         den_ff <= {d2_ff, 23'b0};
         q_ff   <= '0;
         // Field of a live ball reaches the limit, also at the ball center.
         sat_ff <= (r2_ff != '0) && ({13'b0, r2_ff, 12'b0} >= {d2_ff, 24'b0});
      end else if (ctrl.div_step) begin
         rem_ff <= rem_in;
         den_ff <= {1'b0, den_ff[55:1]};
         q_ff   <= q_in;
      end
      if (ctrl.mul_en) begin
         link_ff.f <= f_val;
         link_ff.r <= 32'(col_ff[23:16] * f_val);
         link_ff.g <= 32'(col_ff[15:8] * f_val);
         link_ff.b <= 32'(col_ff[7:0] * f_val);
      end else if (ctrl.shift_en) begin
         link_ff <= link_prev;
      end
   end

   assign link_out = link_ff;

endmodule

/* rtl/metaball_ribbon_pixel_shader_top.sv */
// ----------------------------------------------------------------------------
// Metaball ribbon pixel shader
// Sums the metaball field of a row of ball cells at one pixel and shades it.
// ----------------------------------------------------------------------------
// Usage: items arrive on the req_ channel (req_valid, req_stall). A load item
// (op = 0) writes one ball into the cell chain in the cycle of its transfer and
// returns nothing; the block stays idle after it. A pixel item (op = 1) returns
// one result on the rsp_ channel (rsp_valid, rsp_stall); rsp_valid rises after
// these steps in order: the distance squares, the start and the steps of the
// per-cell serial divider, the color products, shifting the terms out of the
// chain into the accumulator, and loading the output register. A new item is
// taken only after the previous pixel has left the pipeline, so the serial
// divider and the chain drain limit pixel throughput. Write the registers on
// the csr_ channel, which is always ready, only while the block is idle; the
// block itself does not enforce this.
// Reset clears all balls to inactive and the registers to their defaults.
// A stalled result holds in the output register; the next item may still be
// taken and run, and it waits at the end until the output register frees.
// ----------------------------------------------------------------------------
module metaball_ribbon_pixel_shader_top
   import mrps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [5:0]         req_ball_index,
   input  logic signed [15:0] req_ball_x,
   input  logic signed [15:0] req_ball_y,
   input  logic [15:0]        req_ball_radius,
   input  logic [7:0]         req_ball_red,
   input  logic [7:0]         req_ball_green,
   input  logic [7:0]         req_ball_blue,
   input  logic [11:0]        req_pixel_x,
   input  logic [11:0]        req_pixel_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [23:0]        rsp_pixel_rgb,
   output logic               rsp_in_band,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_data
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DIST  = 7'b0000010,
      ST_START = 7'b0000100,
      ST_DIV   = 7'b0001000,
      ST_MUL   = 7'b0010000,
      ST_SHIFT = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [DCNT_W-1:0]  dcnt_ff, dcnt_in;
   logic [CNT_W-1:0]   scnt_ff, scnt_in;
   logic [23:0]        min_ff, max_ff;
   logic [21:0]        xs_ff, ys_ff;
   logic signed [15:0] cx_ff, cy_ff;
   logic [23:0]        sum_ff;
   logic [ACC_W-1:0]   accr_ff, accg_ff, accb_ff;
   logic               rsp_valid_ff;
   logic [23:0]        rgb_ff;
   logic               band_ff;

   ctrl_type           ctrl;
   link_type           links [NUM_BALLS+1];
   logic               accept, out_load;
   logic signed [15:0] cx_in, cy_in;
   logic [24:0]        sum_add;
   logic               band;
   logic [7:0]         cr, cg, cb;

   function automatic logic signed [15:0] to_coord(input logic [21:0] scale,
                                                   input logic [11:0] p);
      logic [33:0]        prod;
      logic signed [28:0] c;
      begin
         prod = 34'(scale * p);
         c = $signed({1'b0, prod[33:6]}) - 29'sd16384;
         if (c > 29'sd32767) to_coord = 16'sh7FFF;
         else to_coord = c[15:0];
      end
   endfunction

   function automatic logic [7:0] clamp8(input logic [ACC_W-1:0] a);
      begin
         clamp8 = (a[ACC_W-1:16] > (ACC_W-16)'(255)) ? 8'hFF : a[23:16];
      end
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      cx_in   = to_coord(xs_ff, req_pixel_x);
      cy_in   = to_coord(ys_ff, req_pixel_y);
      sum_add = {1'b0, sum_ff} + {1'b0, links[NUM_BALLS].f};
      band    = !(sum_ff < min_ff || sum_ff > max_ff);
      cr      = clamp8(accr_ff);
      cg      = clamp8(accg_ff);
      cb      = clamp8(accb_ff);
   end

   always_comb begin
      ctrl = '0;
      state_in = state_ff;
      dcnt_in  = dcnt_ff;
      scnt_in  = scnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_LOAD) ctrl.load_en = 1'b1;
               else state_in = ST_DIST;
            end
         end
         ST_DIST: begin
            ctrl.dist_en = 1'b1;
            state_in = ST_START;
         end
         ST_START: begin
            ctrl.div_start = 1'b1;
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            ctrl.div_step = 1'b1;
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(DIV_STEPS - 1)) state_in = ST_MUL;
         end
         ST_MUL: begin
            ctrl.mul_en = 1'b1;
            scnt_in  = '0;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            ctrl.shift_en = 1'b1;
            scnt_in = scnt_ff + 1'b1;
            if (scnt_ff == CNT_W'(NUM_BALLS - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign links[0] = '0;

   for (genvar i = 0; i < NUM_BALLS; i++) begin : g_cell
      mrps_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .cell_index  (IDX_W'(i)),
         .load_index  (req_ball_index),
         .load_x      (req_ball_x),
         .load_y      (req_ball_y),
         .load_radius (req_ball_radius),
         .load_color  ({req_ball_red, req_ball_green, req_ball_blue}),
         .cx          (cx_ff),
         .cy          (cy_ff),
         .link_prev   (links[i]),
         .link_out    (links[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dcnt_ff      <= '0;
         scnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         min_ff       <= 24'd45875;
         max_ff       <= 24'd52429;
         xs_ff        <= 22'd4096;
         ys_ff        <= 22'd4096;
      end else begin
         state_ff <= state_in;
         dcnt_ff  <= dcnt_in;
         scnt_ff  <= scnt_in;
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (csr_valid) begin
            case (csr_index)
               REG_MIN_LEVEL: min_ff <= csr_data;
               REG_MAX_LEVEL: max_ff <= csr_data;
               REG_X_SCALE:   xs_ff  <= csr_data[21:0];
               REG_Y_SCALE:   ys_ff  <= csr_data[21:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
      end
      if (ctrl.mul_en) begin
         sum_ff  <= '0;
         accr_ff <= '0;
         accg_ff <= '0;
         accb_ff <= '0;
      end else if (ctrl.shift_en) begin
         // The field sum only grows, so clamping the running sum is exact.
         sum_ff  <= sum_add[24] ? F_MAX : sum_add[23:0];
         accr_ff <= accr_ff + ACC_W'(links[NUM_BALLS].r);
         accg_ff <= accg_ff + ACC_W'(links[NUM_BALLS].g);
         accb_ff <= accb_ff + ACC_W'(links[NUM_BALLS].b);
      end
      if (out_load) begin
         rgb_ff  <= band ? {cr, cg, cb} : 24'd0;
         band_ff <= band;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_rgb = rgb_ff;
   assign rsp_in_band   = band_ff;

endmodule

/* dv/metaball_ribbon_pixel_shader_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Metaball ribbon shader testbench
// Loads ball tables, shades pixels under several band and scale settings and
// compares each shaded pixel with a fixed-point field model kept in the bench.
// ----------------------------------------------------------------------------
module metaball_ribbon_pixel_shader_top_tb;
   import mrps_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   class shade_scoreboard;
      logic [23:0] min_lvl, max_lvl;
      logic [21:0] xs, ys;
      logic signed [15:0] bx [NUM_BALLS];
      logic signed [15:0] by [NUM_BALLS];
      logic [15:0] rad [NUM_BALLS];
      logic [23:0] col [NUM_BALLS];
      logic [24:0] pending_pixels [$];
      int mismatches;

      function void clear_state();
         min_lvl = 24'd45875;
         max_lvl = 24'd52429;
         xs = 22'd4096;
         ys = 22'd4096;
         for (int i = 0; i < NUM_BALLS; i++) begin
            bx[i] = 0; by[i] = 0; rad[i] = 0; col[i] = 0;
         end
      endfunction

      function void write_reg(logic [1:0] idx, logic [23:0] data);
         case (idx)
            REG_MIN_LEVEL: min_lvl = data;
            REG_MAX_LEVEL: max_lvl = data;
            REG_X_SCALE: xs = data[21:0];
            REG_Y_SCALE: ys = data[21:0];
            default: ;
         endcase
      endfunction

      function longint coord(logic [21:0] s, logic [11:0] p);
         longint c;
         c = longint'((64'(s) * 64'(p)) >> 6) - 16384;
         if (c > 32767) c = 32767;
         if (c < -32768) c = -32768;
         return c;
      endfunction

      function void note_item(logic op, logic [5:0] idx, logic signed [15:0] x,
                              logic signed [15:0] y, logic [15:0] r,
                              logic [23:0] rgb, logic [11:0] px, logic [11:0] py);
         longint cx, cy, dx, dy;
         longint unsigned d2, r2, f, field, ar, ag, ab, cr, cg, cb;
         logic band;
         if (op == OP_LOAD) begin
            if (idx < NUM_BALLS) begin
               bx[idx] = x; by[idx] = y; rad[idx] = r; col[idx] = rgb;
            end
            return;
         end
         cx = coord(xs, px);
         cy = coord(ys, py);
         field = 0; ar = 0; ag = 0; ab = 0;
         for (int i = 0; i < NUM_BALLS; i++) begin
            dx = cx - longint'(bx[i]);
            dy = cy - longint'(by[i]);
            d2 = dx * dx + dy * dy;
            r2 = 64'(rad[i]) * 64'(rad[i]);
            if (r2 == 0) f = 0;
            else if (d2 == 0) f = F_MAX;
            else begin
               f = (r2 << 12) / d2;
               if (f > F_MAX) f = F_MAX;
            end
            field += f;
            if (field > F_MAX) field = F_MAX;
            ar += col[i][23:16] * f;
            ag += col[i][15:8] * f;
            ab += col[i][7:0] * f;
         end
         band = !(field < min_lvl || field > max_lvl);
         if (band) begin
            cr = ar >> 16; if (cr > 255) cr = 255;
            cg = ag >> 16; if (cg > 255) cg = 255;
            cb = ab >> 16; if (cb > 255) cb = 255;
            pending_pixels.push_back({cr[7:0], cg[7:0], cb[7:0], 1'b1});
         end else
            pending_pixels.push_back(25'd0);
      endfunction

      function void check_pixel(logic [23:0] rgb, logic inb);
         logic [24:0] want;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected pixel rgb=%h band=%b", rgb, inb);
            return;
         end
         want = pending_pixels.pop_front();
         if (want !== {rgb, inb}) begin
            mismatches++;
            if (mismatches <= 10)
               $display("pixel mismatch: expected rgb=%h band=%b, got rgb=%h band=%b",
                        want[24:1], want[0], rgb, inb);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_stall, req_op = 0;
   logic [5:0] req_ball_index = 0;
   logic signed [15:0] req_ball_x = 0, req_ball_y = 0;
   logic [15:0] req_ball_radius = 0;
   logic [7:0] req_ball_red = 0, req_ball_green = 0, req_ball_blue = 0;
   logic [11:0] req_pixel_x = 0, req_pixel_y = 0;
   logic rsp_valid, rsp_stall = 0, rsp_in_band;
   logic [23:0] rsp_pixel_rgb;
   logic csr_valid = 0, csr_ready;
   logic [1:0] csr_index = 0;
   logic [23:0] csr_data = 0;

   shade_scoreboard board = new();
   int idle_cycles = 0;
   int stall_mode = 0;

   always #5 clock = ~clock;

   metaball_ribbon_pixel_shader_top dut (.*);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_pixel(rsp_pixel_rgb, rsp_in_band);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // The receiver cycles through no stalls, light stalls and heavy stalls.
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   task automatic write_csr(logic [1:0] idx, logic [23:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (board.pending_pixels.size() != 0) @(posedge clock);
      repeat (NUM_BALLS + 40) @(posedge clock);
   endtask

   // Drives one transfer; the valid stays high when back to back is wanted.
   task automatic send(logic op, logic [5:0] idx, logic signed [15:0] x,
                       logic signed [15:0] y, logic [15:0] r, logic [23:0] rgb,
                       logic [11:0] px, logic [11:0] py, bit hold);
      @(negedge clock);
      req_valid <= 1'b1;
      req_op <= op; req_ball_index <= idx;
      req_ball_x <= x; req_ball_y <= y; req_ball_radius <= r;
      req_ball_red <= rgb[23:16]; req_ball_green <= rgb[15:8]; req_ball_blue <= rgb[7:0];
      req_pixel_x <= px; req_pixel_y <= py;
      do @(posedge clock); while (req_stall);
      board.note_item(op, idx, x, y, r, rgb, px, py);
      if (!hold) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic load_ball(logic [5:0] idx, logic signed [15:0] x, logic signed [15:0] y,
                            logic [15:0] r, logic [23:0] rgb);
      send(OP_LOAD, idx, x, y, r, rgb, 12'($urandom), 12'($urandom), 1'b0);
   endtask

   task automatic shade(logic [11:0] px, logic [11:0] py, bit hold);
      send(OP_PIXEL, 6'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
           24'($urandom), px, py, hold);
   endtask

   function automatic logic signed [15:0] rand_pos();
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   initial begin
      int burst;
      board.clear_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: ball at the center, inactive ball on a pixel, extremes.
      shade(12'd256, 12'd256, 1'b0);
      load_ball(6'd0, 16'sd0, 16'sd0, 16'hFFFF, 24'hFFFFFF);
      load_ball(6'd1, 16'sd16384, -16'sd16384, 16'd0, 24'hFF00FF);
      load_ball(6'd9, -16'sd16384, 16'sd16384, 16'd300, 24'h00FF00);
      load_ball(6'd63, 16'sd100, 16'sd100, 16'h8000, 24'h123456);
      load_ball(6'd10, 16'sd0, 16'sd0, 16'h8000, 24'hABCDEF);
      shade(12'd256, 12'd256, 1'b0);
      shade(12'd0, 12'd0, 1'b0);
      shade(12'd4095, 12'd4095, 1'b0);
      shade(12'd512, 12'd0, 1'b0);
      drain();
      write_csr(REG_MIN_LEVEL, 24'd0);
      write_csr(REG_MAX_LEVEL, 24'hFFFFFF);
      write_csr(REG_X_SCALE, 24'd0);
      write_csr(REG_Y_SCALE, 24'h3FFFFF);
      shade(12'd4095, 12'd0, 1'b0);
      shade(12'd0, 12'd4095, 1'b0);
      shade(12'd1, 12'd1, 1'b0);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         write_csr(REG_X_SCALE, (phase == 5) ? 24'd2097152 : 24'($urandom_range(512, 8192)));
         write_csr(REG_Y_SCALE, (phase == 4) ? 24'h3FFFFF : 24'($urandom_range(512, 8192)));
         write_csr(REG_MIN_LEVEL, (phase < 2) ? 24'd0 : 24'($urandom_range(0, 65536)));
         write_csr(REG_MAX_LEVEL, (phase == 0) ? 24'hFFFFFF : 24'($urandom_range(32768, 600000)));
         for (int i = 0; i < NUM_BALLS; i++)
            if ($urandom_range(0, 2) != 0)
               load_ball(6'(i), rand_pos(), rand_pos(),
                         ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom),
                         24'($urandom));
         for (int n = 0; n < 100; n += burst) begin
            burst = $urandom_range(1, 8);
            for (int k = 0; k < burst; k++) begin
               if ($urandom_range(0, 9) == 0)
                  load_ball(6'($urandom), rand_pos(), rand_pos(), 16'($urandom),
                            24'($urandom));
               else
                  shade(12'($urandom_range(0, 1023) << (2 * $urandom_range(0, 1))),
                        12'($urandom_range(0, 1023) << (2 * $urandom_range(0, 1))),
                        k < burst - 1);
            end
            if ($urandom_range(0, 3) == 0) begin
               @(negedge clock);
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 60)) @(posedge clock);
            end
            @(negedge clock);
            req_valid <= 1'b0;
            if (n == 48) drain();
         end
         drain();
      end

      if (board.mismatches == 0 && board.pending_pixels.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/mrps_pkg.sv
rtl/mrps_cell.sv
rtl/metaball_ribbon_pixel_shader_top.sv
dv/metaball_ribbon_pixel_shader_top_tb.sv
